// File: hw/rtl/scan_disk_request_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// scan disk request scheduler assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SCAN_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define SCAN_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define SDRS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdrs assertion failed");

// next-cycle implication
`define SDRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdrs assertion failed");

`endif

// File: hw/rtl/sdrs_pkg.sv
// ----------------------------------------------------------------------------
// sdrs_pkg
// shared types and constants of the scan disk request scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdrs_pkg;

   localparam int MAX_REQUESTS_DEFAULT = 32;
   localparam int CYL_WIDTH            = 10;
   localparam int TOTAL_WIDTH          = 16;
   localparam logic [CYL_WIDTH-1:0] START_RESET = 10'd53;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic batch_init;
      logic scan_rd;
      logic emit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/scan_disk_request_scheduler_top.sv
// ----------------------------------------------------------------------------
// scan_disk_request_scheduler_top
// SCAN/LOOK ordering of a batch of cylinder requests.
// Requests load one word per cycle while busy is low; a word with
// req_final_request closes the batch. The block then emits one result per
// stored request: cylinders below the start position falling, then those at
// or above it rising. Each result is found by a full scan of the request store,
// one store read per cycle, then a read drain and an emit. rsp_strobe is high
// for exactly one cycle per result and the receiver cannot stall it; busy stays
// high until the last result is out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scan_disk_request_scheduler_top #(
   parameter int MAX_REQUESTS = sdrs_pkg::MAX_REQUESTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [sdrs_pkg::CYL_WIDTH-1:0]   req_cylinder,
   input  wire logic                             req_final_request,
   input  wire logic                             csr_write_enable,
   input  wire logic [sdrs_pkg::CYL_WIDTH-1:0]   csr_write_data,
   output logic                                  rsp_strobe,
   output logic [sdrs_pkg::CYL_WIDTH-1:0]        rsp_served_cylinder,
   output logic [sdrs_pkg::CYL_WIDTH-1:0]        rsp_seek_distance,
   output logic [sdrs_pkg::TOTAL_WIDTH-1:0]      rsp_seek_sum,
   output logic                                  rsp_last_served,
   output logic                                  rsp_overflowed
);

   sdrs_pkg::cmd_type    cmd;
   sdrs_pkg::status_type status;

   sdrs_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_final_request (req_final_request),
      .status            (status),
      .cmd               (cmd),
      .busy              (busy)
   );

   sdrs_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_cylinder        (req_cylinder),
      .rsp_strobe          (rsp_strobe),
      .rsp_served_cylinder (rsp_served_cylinder),
      .rsp_seek_distance   (rsp_seek_distance),
      .rsp_seek_sum        (rsp_seek_sum),
      .rsp_last_served     (rsp_last_served),
      .rsp_overflowed      (rsp_overflowed)
   );

endmodule

`default_nettype wire

// File: hw/rtl/sdrs_ctrl.sv
// ----------------------------------------------------------------------------
// sdrs_ctrl
// sequencer: load words, then per result one selection scan, a read drain and one emit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdrs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                req_final_request,
   input  wire sdrs_pkg::status_type status,
   output sdrs_pkg::cmd_type        cmd,
   output logic                     busy
);

   sdrs_pkg::state_type state_ff;
   sdrs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdrs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         sdrs_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (req_final_request) begin
                  cmd.batch_init = 1'b1;
                  state_in       = sdrs_pkg::ST_SCAN;
               end
            end
         end
         sdrs_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_end) begin
               state_in = sdrs_pkg::ST_DRAIN;
            end
         end
         sdrs_pkg::ST_DRAIN: begin
            state_in = sdrs_pkg::ST_EMIT;
         end
         sdrs_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               cmd.finish = 1'b1;
               state_in   = sdrs_pkg::ST_IDLE;
            end else begin
               state_in = sdrs_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = sdrs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/sdrs_datapath.sv
// ----------------------------------------------------------------------------
// sdrs_datapath
// request store, selection scan over stored words, seek and total arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdrs_datapath #(
   parameter int MAX_REQUESTS = sdrs_pkg::MAX_REQUESTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sdrs_pkg::cmd_type                   cmd,
   output sdrs_pkg::status_type                     status,
   input  wire logic                                csr_write_enable,
   input  wire logic [sdrs_pkg::CYL_WIDTH-1:0]      csr_write_data,
   input  wire logic [sdrs_pkg::CYL_WIDTH-1:0]      req_cylinder,
   output logic                                     rsp_strobe,
   output logic [sdrs_pkg::CYL_WIDTH-1:0]           rsp_served_cylinder,
   output logic [sdrs_pkg::CYL_WIDTH-1:0]           rsp_seek_distance,
   output logic [sdrs_pkg::TOTAL_WIDTH-1:0]         rsp_seek_sum,
   output logic                                     rsp_last_served,
   output logic                                     rsp_overflowed
);

   localparam int CW = sdrs_pkg::CYL_WIDTH;
   localparam int TW = sdrs_pkg::TOTAL_WIDTH;
   localparam int IW = $clog2(MAX_REQUESTS > 1 ? MAX_REQUESTS : 2);
   localparam int NW = $clog2(MAX_REQUESTS + 1);
   localparam int KW = CW + 1 + IW;

   logic [CW-1:0] store_mem [MAX_REQUESTS];

   logic [CW-1:0] start_ff;
   logic [NW-1:0] count_ff;
   logic          dropped_ff;
   logic [IW-1:0] addr_ff;
   logic [CW-1:0] rd_data_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_vld_ff;
   logic          found_ff;
   logic [KW-1:0] best_ff;
   logic [CW-1:0] best_val_ff;
   logic          have_prev_ff;
   logic [KW-1:0] prev_ff;
   logic [CW-1:0] prev_pos_ff;
   logic [TW-1:0] total_ff;
   logic [NW-1:0] out_cnt_ff;
   logic          rsp_strobe_ff;
   logic [CW-1:0] rsp_cyl_ff;
   logic [CW-1:0] rsp_seek_ff;
   logic [TW-1:0] rsp_sum_ff;
   logic          rsp_last_ff;
   logic          rsp_ovf_ff;

   logic          full;
   logic [NW-1:0] count_last;
   logic          cand_low;
   logic [CW-1:0] cand_off;
   logic [KW-1:0] cand;
   logic          take;
   logic [CW-1:0] dist_in;
   logic [TW:0]   sum_wide;
   logic [TW-1:0] total_in;

   assign full       = (count_ff == NW'(MAX_REQUESTS));
   assign count_last = count_ff - NW'(1);

   assign status = '{scan_end:  (NW'(addr_ff) == count_last),
                     emit_last: (out_cnt_ff == count_last)};

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_served_cylinder = rsp_cyl_ff;
   assign rsp_seek_distance   = rsp_seek_ff;
   assign rsp_seek_sum        = rsp_sum_ff;
   assign rsp_last_served     = rsp_last_ff;
   assign rsp_overflowed      = rsp_ovf_ff;

   // scan key: lows by falling cylinder, then highs by rising cylinder
   always_comb begin
      cand_low = (rd_data_ff < start_ff);
      cand_off = cand_low ? (start_ff - rd_data_ff - CW'(1)) : (rd_data_ff - start_ff);
      cand     = {~cand_low, cand_off, rd_idx_ff};
      take     = rd_vld_ff && (!have_prev_ff || (cand > prev_ff))
                 && (!found_ff || (cand < best_ff));
      dist_in  = (best_val_ff >= prev_pos_ff) ? (best_val_ff - prev_pos_ff)
                                              : (prev_pos_ff - best_val_ff);
      sum_wide = {1'b0, total_ff} + (TW + 1)'(dist_in);
      total_in = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         store_mem[count_ff[IW-1:0]] <= req_cylinder;
      end
      rd_data_ff <= store_mem[addr_ff];
      rd_idx_ff  <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= sdrs_pkg::START_RESET;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         addr_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         have_prev_ff  <= 1'b0;
         out_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            start_ff <= csr_write_data;
         end
         rd_vld_ff     <= cmd.scan_rd;
         rsp_strobe_ff <= cmd.emit;
         if (cmd.finish) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end else if (cmd.load) begin
            if (full) begin
               dropped_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + NW'(1);
            end
         end
         if (cmd.batch_init) begin
            addr_ff      <= '0;
            found_ff     <= 1'b0;
            have_prev_ff <= 1'b0;
            out_cnt_ff   <= '0;
         end else if (cmd.emit) begin
            addr_ff      <= '0;
            found_ff     <= 1'b0;
            have_prev_ff <= 1'b1;
            out_cnt_ff   <= out_cnt_ff + NW'(1);
         end else begin
            if (cmd.scan_rd) begin
               addr_ff <= addr_ff + IW'(1);
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_ff     <= cand;
         best_val_ff <= rd_data_ff;
      end
      if (cmd.batch_init) begin
         prev_pos_ff <= start_ff;
         total_ff    <= '0;
      end else if (cmd.emit) begin
         prev_ff     <= best_ff;
         prev_pos_ff <= best_val_ff;
         total_ff    <= total_in;
      end
      if (cmd.emit) begin
         rsp_cyl_ff  <= best_val_ff;
         rsp_seek_ff <= dist_in;
         rsp_sum_ff  <= total_in;
         rsp_last_ff <= status.emit_last;
         rsp_ovf_ff  <= dropped_ff;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/sdrs_checker.sv
// ----------------------------------------------------------------------------
// sdrs_checker
// port-level checks of the scheduler's batch and result sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "scan_disk_request_scheduler_top_macros.svh"

module sdrs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_final_request,
   input wire logic rsp_strobe,
   input wire logic rsp_last_served
);

   `SDRS_ASSERT_NEXT(a_nonfinal_stays_idle, clock, reset, start && !busy && !req_final_request, !busy)
   `SDRS_ASSERT_NEXT(a_final_goes_busy, clock, reset, start && !busy && req_final_request, busy)
   `SDRS_ASSERT_NEXT(a_results_spaced, clock, reset, rsp_strobe, !rsp_strobe)
   `SDRS_ASSERT_NOW(a_last_frees, clock, reset, rsp_strobe && rsp_last_served, !busy)
   `SDRS_ASSERT_NOW(a_mid_busy, clock, reset, rsp_strobe && !rsp_last_served, busy)

endmodule

bind scan_disk_request_scheduler_top sdrs_checker u_sdrs_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_final_request (req_final_request),
   .rsp_strobe        (rsp_strobe),
   .rsp_last_served   (rsp_last_served)
);

`default_nettype wire
